>>> hdl/tpg_pkg.sv
// Package for the trigger pulse generator: item types, command and status codes.
package tpg_pkg;

    localparam int unsigned CountWidth = 32;
    localparam int unsigned CfgIndexWidth = 2;

    // Register indexes on the configuration port
    localparam logic [CfgIndexWidth-1:0] CFG_MODE        = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_PERIOD      = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_ON_TICKS    = 2'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_PULSE_LIMIT = 2'd3;

    // Reset values of the configuration registers
    localparam logic [CountWidth-1:0] PERIOD_RESET = 32'd1000;
    localparam logic [CountWidth-1:0] ON_RESET     = 32'd1;
    localparam logic [CountWidth-1:0] LIMIT_RESET  = 32'd0;
    localparam logic [CountWidth-1:0] COUNT_MAX    = '1;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STAT_IDLE    = 2'd0,
        STAT_RUNNING = 2'd1,
        STAT_ENDED   = 2'd2
    } status_t;

    typedef enum logic {
        MODE_PERIODIC = 1'b0,
        MODE_EDGE     = 1'b1
    } mode_t;

    typedef struct packed {
        logic [1:0] action;
        logic       trig_in;
    } in_item_t;

    typedef struct packed {
        logic                  trig_out;
        logic [1:0]            run_status;
        logic [CountWidth-1:0] pulse_count;
    } out_item_t;

endpackage

>>> hdl/trigger_pulse_generator_unit.sv
// Trigger pulse generator: periodic and edge-triggered pulse train with one result register.
//
// Usage:
//   in_*  : one transaction per timebase tick; action is tick, start run or stop run,
//           trig_in is the sampled trigger level (judged on ticks in edge mode).
//   out_* : one result transaction per input transaction: output level, run status
//           and the saturating count of completed pulses.
//   cfg_* : register writes (mode, period, pulse length, pulse limit), always ready;
//           the user must write only while no transaction is in flight (the block does not enforce it).
// Timing: the result of a transaction is written into the result register on acceptance.
//   Throughput: one transaction per cycle unless stalled; the whole tick update is a
//   single combinational pass from the state registers to the next state and result.
// Stall: in_ready drops only while a result is held and out_ready is low; the result
//   register holds its transaction until taken, and the next input is accepted in
//   the same cycle as the held result leaves.
// Reset: rst_n clears the run state and result valid, and restores the register
//   defaults (periodic mode, period 1000, pulse length 1, unlimited pulses).
module trigger_pulse_generator_unit
    import tpg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_item_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_item_t                out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CountWidth-1:0]    cfg_data
);

    // configuration registers
    logic                  mode_reg;
    logic [CountWidth-1:0] period_reg;
    logic [CountWidth-1:0] on_reg;
    logic [CountWidth-1:0] limit_reg;

    // run state
    logic                  running_reg, running_next;
    logic                  pulsing_reg, pulsing_next;
    logic                  stop_pending_reg, stop_pending_next;
    logic [CountWidth-1:0] since_reg, since_next;
    logic [CountWidth-1:0] pulse_left_reg, pulse_left_next;
    logic [CountWidth-1:0] done_reg, done_next;
    logic                  last_level_reg, last_level_next;

    // result register
    logic      out_valid_reg;
    out_item_t out_data_reg, out_data_next;

    logic in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // One tick of the timebase, mirroring the run/pulse sequencing.
    always_comb
    begin
        logic                  started;
        logic                  ended;
        logic                  drive;
        logic                  fire;
        logic [CountWidth-1:0] per;
        logic [CountWidth-1:0] len;

        running_next      = running_reg;
        pulsing_next      = pulsing_reg;
        stop_pending_next = stop_pending_reg;
        since_next        = since_reg;
        pulse_left_next   = pulse_left_reg;
        done_next         = done_reg;
        last_level_next   = last_level_reg;
        started           = 1'b0;
        ended             = 1'b0;
        drive             = 1'b0;
        fire              = 1'b0;
        per = (period_reg == '0) ? CountWidth'(1) : period_reg;
        len = (on_reg == '0) ? CountWidth'(1) : on_reg;

        if (!running_reg && in_data.action == ACT_START)
        begin
            running_next      = 1'b1;
            started           = 1'b1;
            done_next         = '0;
            stop_pending_next = 1'b0;
            pulsing_next      = 1'b0;
            pulse_left_next   = '0;
            since_next        = '0;
        end
        else if (running_reg && in_data.action == ACT_STOP)
        begin
            if (pulsing_reg)
            begin
                stop_pending_next = 1'b1;
            end
            else
            begin
                running_next      = 1'b0;
                stop_pending_next = 1'b0;
                ended             = 1'b1;
            end
        end

        if (running_next)
        begin
            if (!pulsing_next)
            begin
                if (mode_reg == MODE_PERIODIC)
                begin
                    fire = started || (since_next >= per);
                end
                else if (!started && in_data.trig_in != last_level_reg)
                begin
                    last_level_next = in_data.trig_in;
                    fire            = 1'b1;
                end
            end
            if (fire)
            begin
                pulsing_next    = 1'b1;
                pulse_left_next = len;
                since_next      = '0;
            end
            if (pulsing_next)
            begin
                drive           = 1'b1;
                pulse_left_next = pulse_left_next - CountWidth'(1);
                if (pulse_left_next == '0)
                begin
                    pulsing_next = 1'b0;
                    if (done_next != COUNT_MAX)
                        done_next = done_next + CountWidth'(1);
                    if (stop_pending_next ||
                        (mode_reg == MODE_PERIODIC && limit_reg != '0 &&
                         done_next >= limit_reg))
                    begin
                        running_next      = 1'b0;
                        stop_pending_next = 1'b0;
                        ended             = 1'b1;
                    end
                end
            end
            if (since_next != COUNT_MAX)
                since_next = since_next + CountWidth'(1);
        end

        out_data_next.trig_out    = drive;
        out_data_next.pulse_count = done_next;
        if (ended)
            out_data_next.run_status = STAT_ENDED;
        else if (running_next)
            out_data_next.run_status = STAT_RUNNING;
        else
            out_data_next.run_status = STAT_IDLE;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PERIODIC;
            period_reg <= PERIOD_RESET;
            on_reg     <= ON_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:        mode_reg   <= cfg_data[0];
                CFG_PERIOD:      period_reg <= cfg_data;
                CFG_ON_TICKS:    on_reg     <= cfg_data;
                CFG_PULSE_LIMIT: limit_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // run state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg      <= 1'b0;
            pulsing_reg      <= 1'b0;
            stop_pending_reg <= 1'b0;
            since_reg        <= '0;
            pulse_left_reg   <= '0;
            done_reg         <= '0;
            last_level_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                running_reg      <= running_next;
                pulsing_reg      <= pulsing_next;
                stop_pending_reg <= stop_pending_next;
                since_reg        <= since_next;
                pulse_left_reg   <= pulse_left_next;
                done_reg         <= done_next;
                last_level_reg   <= last_level_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_data_reg <= out_data_next;
    end

    // a pulse only exists inside a run
    assert property (@(posedge clk) disable iff (!rst_n) pulsing_reg |-> running_reg)
        else $error("pulse active outside a run");

    // a deferred stop is only held while a pulse completes
    assert property (@(posedge clk) disable iff (!rst_n) stop_pending_reg |-> pulsing_reg)
        else $error("stop pending with no pulse active");

    // an active pulse always has ticks remaining
    assert property (@(posedge clk) disable iff (!rst_n)
                     pulsing_reg |-> (pulse_left_reg != '0))
        else $error("active pulse with zero ticks left");

    // output is never driven high while reporting idle
    assert property (@(posedge clk) disable iff (!rst_n)
                     out_valid_reg |-> !(out_data_reg.trig_out &&
                                         out_data_reg.run_status == STAT_IDLE))
        else $error("trigger driven while idle");

    // a held result is not overwritten by a new transaction
    assert property (@(posedge clk) disable iff (!rst_n)
                     (out_valid_reg && !out_ready) |-> !in_fire)
        else $error("input accepted over a stalled result");

endmodule
